// File: rtl/core/clsx_pkg.sv
// Package: token kinds, lexer modes, character class helpers for the C subset lexer.
package clsx_pkg;

  localparam int POSITION_BITS = 16;
  localparam int MAX_STRING_BYTES = 256;
  localparam int KEYWORD_CHARS = 8;
  localparam int MAX_RESULTS = 3;

  localparam logic [5:0] K_NUMBER = 6'd31;
  localparam logic [5:0] K_IDENT  = 6'd32;
  localparam logic [5:0] K_STRING = 6'd45;
  localparam logic [5:0] K_SBYTE  = 6'd46;
  localparam logic [5:0] K_END    = 6'd47;
  localparam logic [5:0] K_ERROR  = 6'd48;

  localparam logic [15:0] E_UNEXPECTED = 16'd1;
  localparam logic [15:0] E_BAD_CHAR   = 16'd2;
  localparam logic [15:0] E_TOO_LONG   = 16'd3;
  localparam logic [15:0] E_EOF_LIT    = 16'd4;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_OP        = 4'd1;
  localparam logic [3:0] M_COMMENT   = 4'd2;
  localparam logic [3:0] M_ZERO      = 4'd3;
  localparam logic [3:0] M_DEC       = 4'd4;
  localparam logic [3:0] M_HEX       = 4'd5;
  localparam logic [3:0] M_BIN       = 4'd6;
  localparam logic [3:0] M_IDENT     = 4'd7;
  localparam logic [3:0] M_CHR_OPEN  = 4'd8;
  localparam logic [3:0] M_CHR_CLOSE = 4'd9;
  localparam logic [3:0] M_STR       = 4'd10;
  localparam logic [3:0] M_STR_ESC   = 4'd11;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [8:0] STR_LIMIT = 9'(MAX_STRING_BYTES - 1);

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] value;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RESULTS-1:0] tok;
    logic [1:0]             n;
  } res_t;

  typedef struct packed {
    logic       en;
    logic [5:0] kind;
  } kind_t;

  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (is_digit(c)) r = {1'b0, 4'(c - "0")};
    else if ((c >= "a") && (c <= "f")) r = {1'b0, 4'(c - "a" + 8'd10)};
    else if ((c >= "A") && (c <= "F")) r = {1'b0, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t r;
    r = '{en: 1'b1, kind: 6'd0};
    unique case (c)
      ";": r.kind = 6'd0;
      ",": r.kind = 6'd1;
      ":": r.kind = 6'd2;
      "[": r.kind = 6'd3;
      "]": r.kind = 6'd4;
      "(": r.kind = 6'd5;
      ")": r.kind = 6'd6;
      "{": r.kind = 6'd7;
      "}": r.kind = 6'd8;
      ".": r.kind = 6'd9;
      "%": r.kind = 6'd10;
      "*": r.kind = 6'd15;
      "#": r.kind = 6'd16;
      "~": r.kind = 6'd17;
      default: r.en = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_t lead_kind(input logic [7:0] c);
    kind_t r;
    r = '{en: 1'b1, kind: 6'd0};
    unique case (c)
      "+": r.kind = 6'd11;
      "-": r.kind = 6'd13;
      "!": r.kind = 6'd18;
      "/": r.kind = 6'd20;
      "=": r.kind = 6'd21;
      "&": r.kind = 6'd23;
      "|": r.kind = 6'd25;
      ">": r.kind = 6'd27;
      "<": r.kind = 6'd29;
      default: r.en = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_t r;
    r = '{en: 1'b1, kind: 6'd0};
    priority if (a == "+" && b == "+") r.kind = 6'd12;
    else if (a == "-" && b == "-") r.kind = 6'd14;
    else if (a == "!" && b == "=") r.kind = 6'd19;
    else if (a == "=" && b == "=") r.kind = 6'd22;
    else if (a == "&" && b == "&") r.kind = 6'd24;
    else if (a == "|" && b == "|") r.kind = 6'd26;
    else if (a == ">" && b == "=") r.kind = 6'd28;
    else if (a == "<" && b == "=") r.kind = 6'd30;
    else r.en = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    unique case (c)
      "n": r = 8'd10;
      "t": r = 8'd9;
      "r": r = 8'd13;
      "a": r = 8'd7;
      "b": r = 8'd8;
      "0": r = 8'd0;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [15:0] len, input prefix_t p);
    logic [5:0] r;
    r = K_IDENT;
    unique case (len)
      16'd2: if ({p[0], p[1]} == "if") r = 6'd36;
      16'd3: begin
        if ({p[0], p[1], p[2]} == "int") r = 6'd33;
        else if ({p[0], p[1], p[2]} == "for") r = 6'd39;
      end
      16'd4: begin
        if ({p[0], p[1], p[2], p[3]} == "char") r = 6'd34;
        else if ({p[0], p[1], p[2], p[3]} == "void") r = 6'd35;
        else if ({p[0], p[1], p[2], p[3]} == "else") r = 6'd37;
      end
      16'd5: begin
        if ({p[0], p[1], p[2], p[3], p[4]} == "while") r = 6'd38;
        else if ({p[0], p[1], p[2], p[3], p[4]} == "break") r = 6'd40;
      end
      16'd6: begin
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "return") r = 6'd42;
        else if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "struct") r = 6'd43;
        else if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "sizeof") r = 6'd44;
      end
      16'd8: if ({p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]} == "continue") r = 6'd41;
      default: r = K_IDENT;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] grow16(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  function automatic logic [15:0] sat_pos(input logic [POSITION_BITS-1:0] x);
    return (x > POSITION_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(x);
  endfunction

endpackage

// File: rtl/core/clsx_step.sv
// Lexer state registers and the single-pass next-state and token logic.
module clsx_step import clsx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] c,
  input  logic       last,
  output res_t       res,
  output logic       halted_o
);

  logic [3:0]               mode, mode_next;
  logic [7:0]               pend, pend_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [15:0]              tstart, tstart_next;
  logic [15:0]              len, len_next;
  logic [15:0]              val, val_next;
  prefix_t                  pre, pre_next;
  logic [8:0]               scount, scount_next;
  logic                     halted, halted_next;

  always_comb begin
    logic [1:0]  k;
    logic        do_begin;
    logic [15:0] p16;
    kind_t       pk, sk, lk;
    logic [4:0]  hd;
    logic        fin_en;
    logic [5:0]  fin_kind;
    logic [15:0] fin_len, fin_val;
    k = 2'd0;
    do_begin = 1'b0;
    p16 = sat_pos(pos);
    pk = pair_kind(pend, c);
    sk = single_kind(c);
    lk = lead_kind(c);
    hd = hex_digit(c);
    fin_en = 1'b0;
    fin_kind = K_NUMBER;
    fin_len = 16'd0;
    fin_val = 16'd0;
    res = '0;
    mode_next = mode;
    pend_next = pend;
    pos_next = pos;
    tstart_next = tstart;
    len_next = len;
    val_next = val;
    pre_next = pre;
    scount_next = scount;
    halted_next = halted;
    if (!halted) begin
      fin_en = 1'b1;
      unique case (mode)
        M_OP: fin_kind = lead_kind(pend).kind;
        M_ZERO, M_DEC, M_HEX, M_BIN: fin_kind = K_NUMBER;
        M_IDENT: fin_kind = ident_kind(len, pre);
        default: fin_en = 1'b0;
      endcase
      fin_len = (mode == M_OP) ? 16'd1 : len;
      fin_val = (mode == M_OP || mode == M_IDENT) ? 16'd0 : val;
      unique case (mode)
        M_OP: begin
          if (pend == "/" && c == "/") begin
            mode_next = M_COMMENT;
          end else if (pk.en) begin
            res.tok[k] = '{pk.kind, tstart, 16'd2, 16'd0};
            k = k + 2'd1;
            mode_next = M_IDLE;
          end else begin
            do_begin = 1'b1;
          end
        end
        M_COMMENT: if (c == 8'd10) mode_next = M_IDLE;
        M_ZERO: begin
          if (c == "x") begin
            mode_next = M_HEX;
            len_next = grow16(len);
          end else if (c == "b") begin
            mode_next = M_BIN;
            len_next = grow16(len);
          end else if (is_digit(c)) begin
            mode_next = M_DEC;
            val_next = 16'(c - "0");
            len_next = grow16(len);
          end else begin
            do_begin = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(c)) begin
            val_next = (val << 3) + (val << 1) + 16'(c - "0");
            len_next = grow16(len);
          end else begin
            do_begin = 1'b1;
          end
        end
        M_HEX: begin
          if (!hd[4]) begin
            val_next = (val << 4) + 16'(hd[3:0]);
            len_next = grow16(len);
          end else begin
            do_begin = 1'b1;
          end
        end
        M_BIN: begin
          if (c == "0" || c == "1") begin
            val_next = (val << 1) + 16'(c[0]);
            len_next = grow16(len);
          end else begin
            do_begin = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (len < 16'(KEYWORD_CHARS)) pre_next[len[2:0]] = c;
            len_next = grow16(len);
          end else begin
            do_begin = 1'b1;
          end
        end
        M_CHR_OPEN: begin
          if (c == 8'd0) begin
            res.tok[k] = '{K_ERROR, p16, 16'd0, E_BAD_CHAR};
            k = k + 2'd1;
            halted_next = 1'b1;
          end else begin
            val_next = 16'(c);
            mode_next = M_CHR_CLOSE;
          end
        end
        M_CHR_CLOSE: begin
          if (c == "'") begin
            res.tok[k] = '{K_NUMBER, tstart, 16'd3, val};
            k = k + 2'd1;
            mode_next = M_IDLE;
          end else begin
            res.tok[k] = '{K_ERROR, p16, 16'd0, E_BAD_CHAR};
            k = k + 2'd1;
            halted_next = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            len_next = grow16(len);
            res.tok[k] = '{K_STRING, tstart, len_next, 16'(scount)};
            k = k + 2'd1;
            mode_next = M_IDLE;
          end else if (scount >= STR_LIMIT) begin
            res.tok[k] = '{K_ERROR, p16, 16'd0, E_TOO_LONG};
            k = k + 2'd1;
            halted_next = 1'b1;
          end else if (c == "\\") begin
            mode_next = M_STR_ESC;
            len_next = grow16(len);
          end else begin
            res.tok[k] = '{K_SBYTE, p16, 16'd1, 16'(c)};
            k = k + 2'd1;
            scount_next = scount + 9'd1;
            len_next = grow16(len);
          end
        end
        M_STR_ESC: begin
          res.tok[k] = '{K_SBYTE, p16, 16'd2, 16'(unescape(c))};
          k = k + 2'd1;
          scount_next = scount + 9'd1;
          len_next = grow16(len);
          mode_next = M_STR;
        end
        default: do_begin = 1'b1;
      endcase
      if (do_begin) begin
        if (fin_en) begin
          res.tok[k] = '{fin_kind, tstart, fin_len, fin_val};
          k = k + 2'd1;
        end
        mode_next = M_IDLE;
        if (c == " " || c == 8'd9 || c == 8'd10) begin
          mode_next = M_IDLE;
        end else if (sk.en) begin
          res.tok[k] = '{sk.kind, p16, 16'd1, 16'd0};
          k = k + 2'd1;
        end else begin
          tstart_next = p16;
          len_next = 16'd1;
          val_next = 16'd0;
          if (lk.en) begin
            mode_next = M_OP;
            pend_next = c;
          end else if (c == "'") begin
            mode_next = M_CHR_OPEN;
          end else if (c == "\"") begin
            mode_next = M_STR;
            scount_next = 9'd0;
          end else if (c == "0") begin
            mode_next = M_ZERO;
          end else if (is_digit(c)) begin
            mode_next = M_DEC;
            val_next = 16'(c - "0");
          end else if (is_alpha(c)) begin
            mode_next = M_IDENT;
            pre_next[0] = c;
          end else begin
            res.tok[k] = '{K_ERROR, p16, 16'd0, E_UNEXPECTED};
            k = k + 2'd1;
            halted_next = 1'b1;
          end
        end
      end
      if (pos < POS_MAX) pos_next = pos + POSITION_BITS'(1);
      if (!halted_next && last) begin
        if (mode_next == M_CHR_OPEN || mode_next == M_CHR_CLOSE ||
            mode_next == M_STR || mode_next == M_STR_ESC) begin
          res.tok[k] = '{K_ERROR, p16, 16'd0, E_EOF_LIT};
          k = k + 2'd1;
          halted_next = 1'b1;
        end else begin
          fin_en = 1'b1;
          unique case (mode_next)
            M_OP: fin_kind = lead_kind(pend_next).kind;
            M_ZERO, M_DEC, M_HEX, M_BIN: fin_kind = K_NUMBER;
            M_IDENT: fin_kind = ident_kind(len_next, pre_next);
            default: fin_en = 1'b0;
          endcase
          fin_len = (mode_next == M_OP) ? 16'd1 : len_next;
          fin_val = (mode_next == M_OP || mode_next == M_IDENT) ? 16'd0 : val_next;
          if (fin_en) begin
            res.tok[k] = '{fin_kind, tstart_next, fin_len, fin_val};
            k = k + 2'd1;
          end
          res.tok[k] = '{K_END, sat_pos(pos_next), 16'd0, 16'd0};
          k = k + 2'd1;
          mode_next = M_IDLE;
          pend_next = 8'd0;
          pos_next = '0;
          tstart_next = 16'd0;
          len_next = 16'd0;
          val_next = 16'd0;
          scount_next = 9'd0;
        end
      end
    end
    res.n = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= 8'd0;
      pos <= '0;
      tstart <= 16'd0;
      len <= 16'd0;
      val <= 16'd0;
      scount <= 9'd0;
      halted <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      pend <= pend_next;
      pos <= pos_next;
      tstart <= tstart_next;
      len <= len_next;
      val <= val_next;
      scount <= scount_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pre <= pre_next;
  end

  assign halted_o = halted;

endmodule

// File: rtl/core/clsx_outbuf.sv
// Result buffer: holds the tokens of one source byte and sends them one word at a time.
module clsx_outbuf import clsx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  output logic        ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output tok_t        tok,
  output logic        tlast,
  output logic [1:0]  cnt_o,
  output logic [1:0]  idx_o
);

  tok_t [MAX_RESULTS-1:0] buf_tok;
  logic [1:0]             cnt;
  logic [1:0]             idx;

  assign m_tvalid = (idx != cnt);
  assign ready = (idx == cnt) || ((idx + 2'd1 == cnt) && m_tready);
  assign tok = buf_tok[idx];
  assign tlast = (idx + 2'd1 == cnt);
  assign cnt_o = cnt;
  assign idx_o = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= res.n;
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) buf_tok <= res.tok;
  end

endmodule

// File: rtl/core/c_subset_lexer_core.sv
// Top level of the C subset lexer: byte stream in, token stream out.
//
// Slave channel: one source byte per word, tlast marks the last byte of the
// source. Master channel: one token per word, tlast marks the final token
// caused by a source byte.
// Each accepted byte is decoded in the cycle it arrives and its tokens (zero
// to three) appear on the master side in the next cycle.
// Throughput is one byte per cycle while each byte yields at most one token and
// the master side is ready; a byte that yields more tokens holds s_tready low
// until its last token is being sent, as a single result buffer feeds the master port.
// A stall on the master side holds the buffered tokens and drops s_tready
// once the buffer cannot drain this cycle.
// Reset clears the lexer to idle, the position to zero and the buffer to
// empty. After an error token the lexer takes bytes and gives no tokens
// until reset.
module c_subset_lexer_core import clsx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // src_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // token_kind, start_offset, token_length, token_value, pad
  output logic        m_tlast    // last_of_run
);

  res_t res;
  tok_t tok;
  logic accept;
  logic halted;
  logic [1:0] cnt;
  logic [1:0] idx;

  assign accept = s_tvalid && s_tready;

  clsx_step u_step (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .c        (s_tdata),
    .last     (s_tlast),
    .res      (res),
    .halted_o (halted)
  );

  clsx_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .tok      (tok),
    .tlast    (m_tlast),
    .cnt_o    (cnt),
    .idx_o    (idx)
  );

  assign m_tdata = {2'b00, tok.value, tok.len, tok.start, tok.kind};

  a_idx_bound: assert property (@(posedge clk) disable iff (rst) idx <= cnt)
    else $error("result index past count");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    accept && res.n != 2'd0 |=> m_tvalid)
    else $error("tokens lost on load");
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> res.n == 2'd0)
    else $error("tokens after halt");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !m_tlast |-> !s_tready)
    else $error("ready while tokens pending");

endmodule
